@@ src/bdq_pkg.sv @@
// shared types and constants for the bounded deque with search
// operation codes, controller states, command and status bundles
// no dependencies

package bdq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int OP_W           = 3;
    localparam int VALUE_W        = 32;
    localparam int COUNT_W        = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_WAIT,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic push_exec;
        logic pop_issue;
        logic pop_finish;
        logic res_fail;
        logic res_search_empty;
        logic scan_start;
        logic scan_next;
        logic scan_finish;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            hit;
        logic            last;
        logic            out_busy;
    } status_t;

endpackage

@@ src/bounded_deque_with_search_unit.sv @@
// top level of the bounded deque with search
// depends on bdq_pkg, bdq_ctrl and bdq_dp
//
// usage:
// - input channel in_valid / in_stall carries op and value; output channel
//   out_valid / out_stall carries ok, popped, found and count
// - a transfer happens on a rising edge with valid high and stall low
// - one item is worked on at a time; in_stall is high from the transfer until
//   its result is in the output register
// - from input transfer to out_valid an item goes through the execute and done
//   states; a pop adds a read wait state, and a search adds a scan state for each
//   stored word it compares (at most the fill count, up to DEPTH)
// - a new item is taken the cycle after its predecessor's result is loaded;
//   the search walks the store one word per cycle through the single read port
//   of the ring ram
// - the output register holds a result while out_stall is high; a finished
//   result waits there while the next item is accepted, and that item's
//   result is not loaded until the register is free
// - reset empties the deque (head and fill count cleared) and drops any
//   pending result; store contents are not cleared

module bounded_deque_with_search_unit #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = bdq_pkg::ELEM_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bdq_pkg::OP_W-1:0]     op,
    input  logic [bdq_pkg::VALUE_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         ok,
    output logic [bdq_pkg::VALUE_W-1:0]  popped,
    output logic                         found,
    output logic [bdq_pkg::COUNT_W-1:0]  count
);

    bdq_pkg::cmd_t    cmd;
    bdq_pkg::status_t st;

    bdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    bdq_dp #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .popped    (popped),
        .found     (found),
        .count     (count),
        .cmd       (cmd),
        .st        (st)
    );

`ifndef ASSERT_OFF
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item is in progress");

    a_fail_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (popped == '0 && !found))
        else $error("failed result carries data");

    a_found_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> (ok && popped == '0))
        else $error("found flag on a non-search result");

    a_one_result_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.push_exec, cmd.pop_issue, cmd.res_fail, cmd.res_search_empty,
                  cmd.scan_start, cmd.pop_finish, cmd.scan_finish, cmd.out_load}))
        else $error("conflicting datapath commands");
`endif

endmodule

@@ src/bdq_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/bdq_ctrl.sv @@
// controller state machine for the bounded deque with search
// depends on bdq_pkg for states, op codes, command and status bundles

module bdq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  bdq_pkg::status_t st,
    output bdq_pkg::cmd_t    cmd
);

    bdq_pkg::state_t state_reg;
    bdq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = bdq_pkg::ST_EXEC;
                end
            end
            bdq_pkg::ST_EXEC:
            begin
                state_next = bdq_pkg::ST_DONE;
                unique case (st.op)
                    bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK:
                    begin
                        if (st.full)
                        begin
                            cmd.res_fail = 1'b1;
                        end
                        else
                        begin
                            cmd.push_exec = 1'b1;
                        end
                    end
                    bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK:
                    begin
                        if (st.empty)
                        begin
                            cmd.res_fail = 1'b1;
                        end
                        else
                        begin
                            cmd.pop_issue = 1'b1;
                            state_next    = bdq_pkg::ST_POP_WAIT;
                        end
                    end
                    bdq_pkg::OP_SEARCH:
                    begin
                        if (st.empty)
                        begin
                            cmd.res_search_empty = 1'b1;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = bdq_pkg::ST_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.res_fail = 1'b1;
                    end
                endcase
            end
            bdq_pkg::ST_POP_WAIT:
            begin
                cmd.pop_finish = 1'b1;
                state_next     = bdq_pkg::ST_DONE;
            end
            bdq_pkg::ST_SCAN:
            begin
                if (st.hit || st.last)
                begin
                    cmd.scan_finish = 1'b1;
                    state_next      = bdq_pkg::ST_DONE;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                end
            end
            bdq_pkg::ST_DONE:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = bdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/bdq_dp.sv @@
// datapath for the bounded deque with search: ring pointers, word store,
// scan compare, result and output registers
// depends on bdq_pkg and bdq_ram

module bdq_dp #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = bdq_pkg::ELEM_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [bdq_pkg::OP_W-1:0]     op,
    input  logic [bdq_pkg::VALUE_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         ok,
    output logic [bdq_pkg::VALUE_W-1:0]  popped,
    output logic                         found,
    output logic [bdq_pkg::COUNT_W-1:0]  count,
    input  bdq_pkg::cmd_t                cmd,
    output bdq_pkg::status_t             st
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int EW  = ELEM_WIDTH;
    localparam int VW  = bdq_pkg::VALUE_W;
    localparam int NW  = bdq_pkg::COUNT_W;
    localparam int OPW = bdq_pkg::OP_W;

    logic [AW-1:0]  head_reg;
    logic [AW-1:0]  head_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic           out_valid_reg;
    logic           out_valid_next;

    logic [OPW-1:0] op_reg;
    logic [EW-1:0]  val_reg;
    logic [AW-1:0]  scan_addr_reg;
    logic [CW-1:0]  idx_reg;
    logic           res_ok_reg;
    logic [EW-1:0]  res_popped_reg;
    logic           res_found_reg;
    logic           out_ok_reg;
    logic [EW-1:0]  out_popped_reg;
    logic           out_found_reg;
    logic [CW-1:0]  out_cnt_reg;

    logic [AW-1:0]  head_inc;
    logic [AW-1:0]  head_dec;
    logic [AW-1:0]  scan_inc;
    logic [AW:0]    tail_sum;
    logic [AW-1:0]  tail_addr;
    logic [CW-1:0]  cnt_m1;
    logic [AW:0]    back_sum;
    logic [AW-1:0]  back_addr;
    logic           is_front;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [AW-1:0]  ram_raddr;
    logic [EW-1:0]  ram_rdata;

    assign is_front = (op_reg == bdq_pkg::OP_PUSH_FRONT) || (op_reg == bdq_pkg::OP_POP_FRONT);

    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign scan_inc = (scan_addr_reg == AW'(DEPTH - 1)) ? '0 : scan_addr_reg + 1'b1;

    assign tail_sum  = (AW+1)'(head_reg) + (AW+1)'(cnt_reg);
    assign tail_addr = (tail_sum >= (AW+1)'(DEPTH)) ? AW'(tail_sum - (AW+1)'(DEPTH))
                                                    : AW'(tail_sum);
    assign cnt_m1    = cnt_reg - 1'b1;
    assign back_sum  = (AW+1)'(head_reg) + (AW+1)'(cnt_m1);
    assign back_addr = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                                    : AW'(back_sum);

    assign ram_we    = cmd.push_exec;
    assign ram_waddr = is_front ? head_dec : tail_addr;

    always_comb
    begin
        if (cmd.pop_issue)
        begin
            ram_raddr = is_front ? head_reg : back_addr;
        end
        else if (cmd.scan_start)
        begin
            ram_raddr = head_reg;
        end
        else if (cmd.scan_next)
        begin
            ram_raddr = scan_inc;
        end
        else
        begin
            ram_raddr = '0;
        end
    end

    bdq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (val_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (cmd.push_exec)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (is_front)
            begin
                head_next = head_dec;
            end
        end
        if (cmd.pop_finish)
        begin
            cnt_next = cnt_m1;
            if (is_front)
            begin
                head_next = head_inc;
            end
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg  <= op;
            val_reg <= EW'(value);
        end
        if (cmd.scan_start)
        begin
            scan_addr_reg <= head_reg;
            idx_reg       <= '0;
        end
        if (cmd.scan_next)
        begin
            scan_addr_reg <= scan_inc;
            idx_reg       <= idx_reg + 1'b1;
        end
        if (cmd.push_exec)
        begin
            res_ok_reg     <= 1'b1;
            res_popped_reg <= '0;
            res_found_reg  <= 1'b0;
        end
        if (cmd.pop_finish)
        begin
            res_ok_reg     <= 1'b1;
            res_popped_reg <= ram_rdata;
            res_found_reg  <= 1'b0;
        end
        if (cmd.res_fail)
        begin
            res_ok_reg     <= 1'b0;
            res_popped_reg <= '0;
            res_found_reg  <= 1'b0;
        end
        if (cmd.res_search_empty)
        begin
            res_ok_reg     <= 1'b1;
            res_popped_reg <= '0;
            res_found_reg  <= 1'b0;
        end
        if (cmd.scan_finish)
        begin
            res_ok_reg     <= 1'b1;
            res_popped_reg <= '0;
            res_found_reg  <= st.hit;
        end
        if (cmd.out_load)
        begin
            out_ok_reg     <= res_ok_reg;
            out_popped_reg <= res_popped_reg;
            out_found_reg  <= res_found_reg;
            out_cnt_reg    <= cnt_reg;
        end
    end

    assign st.op       = op_reg;
    assign st.full     = (cnt_reg == CW'(DEPTH));
    assign st.empty    = (cnt_reg == '0);
    assign st.hit      = (ram_rdata == val_reg);
    assign st.last     = ((idx_reg + 1'b1) == cnt_reg);
    assign st.out_busy = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign ok        = out_ok_reg;
    assign popped    = VW'(out_popped_reg);
    assign found     = out_found_reg;
    assign count     = NW'(out_cnt_reg);

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for bounded_deque_with_search_unit
// predicts every deque operation in a small scoreboard class; needs bdq_pkg and the unit

module tb;

    localparam int DEPTH   = bdq_pkg::DEPTH_DEF;
    localparam int ELEM_W  = bdq_pkg::ELEM_WIDTH_DEF;
    localparam int OP_W    = bdq_pkg::OP_W;
    localparam int VALUE_W = bdq_pkg::VALUE_W;
    localparam int COUNT_W = bdq_pkg::COUNT_W;
    localparam int LIMIT   = 400000;
    localparam logic [VALUE_W-1:0] ELEM_MASK = VALUE_W'((64'd1 << ELEM_W) - 64'd1);
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIXED = 2;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] popped;
        logic               found;
        logic [COUNT_W-1:0] count;
    } deque_result_t;

    class deque_scoreboard;
        logic [VALUE_W-1:0] ring [DEPTH];
        int unsigned        head;
        int unsigned        fill;
        deque_result_t      awaiting [$];
        int unsigned        fail_count;

        function new();
            head       = 0;
            fill       = 0;
            fail_count = 0;
        endfunction

        function void note_input(logic [OP_W-1:0] o, logic [VALUE_W-1:0] v);
            deque_result_t      r;
            logic [VALUE_W-1:0] word;
            r    = '0;
            word = v & ELEM_MASK;
            case (o)
                bdq_pkg::OP_PUSH_FRONT:
                    if (fill < DEPTH)
                    begin
                        head       = (head + DEPTH - 1) % DEPTH;
                        ring[head] = word;
                        fill++;
                        r.ok = 1'b1;
                    end
                bdq_pkg::OP_PUSH_BACK:
                    if (fill < DEPTH)
                    begin
                        ring[(head + fill) % DEPTH] = word;
                        fill++;
                        r.ok = 1'b1;
                    end
                bdq_pkg::OP_POP_FRONT:
                    if (fill > 0)
                    begin
                        r.popped = ring[head];
                        head     = (head + 1) % DEPTH;
                        fill--;
                        r.ok = 1'b1;
                    end
                bdq_pkg::OP_POP_BACK:
                    if (fill > 0)
                    begin
                        r.popped = ring[(head + fill - 1) % DEPTH];
                        fill--;
                        r.ok = 1'b1;
                    end
                bdq_pkg::OP_SEARCH:
                begin
                    r.ok = 1'b1;
                    for (int i = 0; i < fill; i++)
                        if (ring[(head + i) % DEPTH] == word)
                            r.found = 1'b1;
                end
                default:
                    ;
            endcase
            r.count = COUNT_W'(fill);
            awaiting.push_back(r);
        endfunction

        function void check_result(logic a_ok, logic [VALUE_W-1:0] a_popped, logic a_found,
                                   logic [COUNT_W-1:0] a_count);
            deque_result_t e;
            if (awaiting.size() == 0)
            begin
                $error("result transfer with no operation pending");
                fail_count++;
                return;
            end
            e = awaiting.pop_front();
            if (a_ok !== e.ok)
            begin
                $error("ok: expected %0d, got %0d", e.ok, a_ok);
                fail_count++;
            end
            if (a_popped !== e.popped)
            begin
                $error("popped: expected %h, got %h", e.popped, a_popped);
                fail_count++;
            end
            if (a_found !== e.found)
            begin
                $error("found: expected %0d, got %0d", e.found, a_found);
                fail_count++;
            end
            if (a_count !== e.count)
            begin
                $error("count: expected %0d, got %0d", e.count, a_count);
                fail_count++;
            end
        endfunction

        function int pending();
            return awaiting.size();
        endfunction

        function logic [VALUE_W-1:0] stored_word();
            return ring[(head + $urandom_range(0, fill - 1)) % DEPTH];
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic               out_valid;
    logic               out_stall;
    logic               ok;
    logic [VALUE_W-1:0] popped;
    logic               found;
    logic [COUNT_W-1:0] count;

    deque_scoreboard sb = new();
    int unsigned     cycles = 0;
    int              burst_left = 1;
    int              gap_max = 0;
    int              phase = PH_FILL;

    bounded_deque_with_search_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .popped    (popped),
        .found     (found),
        .count     (count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("bounded_deque_with_search_unit regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(ok, popped, found, count);

    // receiver stall pattern: free-running, bursty, or long holds
    initial
    begin
        int mode;
        int len;
        out_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 80);
            for (int k = 0; k < len; k++)
            begin
                @(negedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 1) == 1);
                    default: out_stall <= ((k % 12) < 9);
                endcase
            end
        end
    end

    task automatic send_item(logic [OP_W-1:0] o, logic [VALUE_W-1:0] v);
        @(negedge clk);
        in_valid <= 1'b1;
        op       <= o;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(o, v);
    endtask

    task automatic put(logic [OP_W-1:0] o, logic [VALUE_W-1:0] v);
        int gap;
        send_item(o, v);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, gap_max);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
            gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 35)
            return VALUE_W'($urandom_range(0, 3));
        return $urandom;
    endfunction

    task automatic random_item(output logic [OP_W-1:0] o, output logic [VALUE_W-1:0] v);
        int r;
        int push_lim;
        int pop_lim;
        r = $urandom_range(0, 99);
        case (phase)
            PH_FILL:
            begin
                push_lim = 75;
                pop_lim  = 85;
            end
            PH_DRAIN:
            begin
                push_lim = 15;
                pop_lim  = 85;
            end
            default:
            begin
                push_lim = 37;
                pop_lim  = 72;
            end
        endcase
        v = pick_word();
        if (r < 3)
        begin
            case ($urandom_range(0, 2))
                0: o = OP_RSVD_5;
                1: o = OP_RSVD_6;
                default: o = OP_RSVD_7;
            endcase
        end
        else if (r < push_lim)
            o = $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK;
        else if (r < pop_lim)
            o = $urandom_range(0, 1) ? bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_POP_BACK;
        else
        begin
            o = bdq_pkg::OP_SEARCH;
            if (sb.fill > 0 && $urandom_range(0, 1))
                v = sb.stored_word();
        end
    endtask

    initial
    begin
        logic [OP_W-1:0]    o;
        logic [VALUE_W-1:0] v;
        int                 phase_left;
        in_valid = 1'b0;
        op       = '0;
        value    = '0;
        rst_n    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty store, both ends, wide words, unused codes
        put(bdq_pkg::OP_SEARCH, '0);
        put(bdq_pkg::OP_POP_FRONT, '1);
        put(bdq_pkg::OP_POP_BACK, '1);
        put(bdq_pkg::OP_PUSH_FRONT, '0);
        put(bdq_pkg::OP_PUSH_BACK, '1);
        put(bdq_pkg::OP_PUSH_FRONT, 32'h8000_0001);
        put(bdq_pkg::OP_SEARCH, '1);
        put(bdq_pkg::OP_SEARCH, 32'h1234_5678);
        put(bdq_pkg::OP_SEARCH, '0);
        put(OP_RSVD_5, '1);
        put(OP_RSVD_6, '1);
        put(OP_RSVD_7, '1);
        put(bdq_pkg::OP_POP_BACK, '0);
        put(bdq_pkg::OP_POP_FRONT, '0);
        put(bdq_pkg::OP_POP_FRONT, '1);
        put(bdq_pkg::OP_POP_BACK, '0);
        hold_until_drained();

        phase      = PH_FILL;
        phase_left = 50;
        for (int n = 0; n < 500; n++)
        begin
            if (n == 250)
                hold_until_drained();
            if (phase_left == 0)
            begin
                phase      = $urandom_range(PH_FILL, PH_MIXED);
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            random_item(o, v);
            put(o, v);
        end
        hold_until_drained();
        repeat (25) @(posedge clk);

        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("bounded_deque_with_search_unit regression: pass");
        else
            $display("bounded_deque_with_search_unit regression: fail");
        $finish;
    end

endmodule
